@@ hdl/ads_pkg.sv @@
// Shared constants for the aliquot divisor sum block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ads_pkg;

    // Default width of the input integer
    localparam int VALUE_WIDTH_DEFAULT = 32;

    // Width of the divisor sum result
    localparam int SUM_WIDTH = 35;

endpackage : ads_pkg

@@ hdl/ads_div.sv @@
// Restoring radix-2 divider that produces one quotient bit per cycle.
// Depends on ads_pkg; used by aliquot_divisor_sum.
`timescale 1ns / 1ps

module ads_div #(
    parameter int VALUE_WIDTH = ads_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [VALUE_WIDTH-1:0] divisor,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] quotient,
    output logic [VALUE_WIDTH-1:0] remainder
);
    import ads_pkg::*;

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic                   busy_reg;
    logic                   busy_next;
    logic                   done_reg;
    logic                   done_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    logic [VALUE_WIDTH-1:0] quo_reg;
    logic [VALUE_WIDTH-1:0] quo_next;
    logic [VALUE_WIDTH-1:0] rem_reg;
    logic [VALUE_WIDTH-1:0] rem_next;

    logic [VALUE_WIDTH:0]   rem_shift;
    logic [VALUE_WIDTH:0]   rem_diff;

    // Shift in the next dividend bit and try a subtract
    assign rem_shift = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            // Load the dividend and clear the partial remainder
            busy_next = 1'b1;
            cnt_next  = CNT_W'(VALUE_WIDTH);
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // Keep the difference when it did not go negative
            if (!rem_diff[VALUE_WIDTH])
            begin
                rem_next = rem_diff[VALUE_WIDTH-1:0];
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[VALUE_WIDTH-1:0];
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Advance the quotient and remainder
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule : ads_div

@@ hdl/aliquot_divisor_sum.sv @@
// Top level of the aliquot divisor sum block: sequencer and accumulator.
// Depends on ads_pkg and ads_div.
`timescale 1ns / 1ps

// Sums the proper divisors of value_n by trial division with candidates d
// from 2 upward. One shared restoring divider computes n / d and n % d for
// each candidate; the search stops once d exceeds the quotient, which is the
// same as d * d > n. Each candidate runs a start state, the divider steps,
// a wait for the divider to finish and a check state; an input below 2 skips
// the search and gives a sum of zero. The input stalls while an item is in
// work; a finished result waits in the output register and the next item may
// be taken meanwhile. The sum saturates at 2^35 - 1, which only a VALUE_WIDTH
// above 32 can reach.

module aliquot_divisor_sum #(
    parameter int VALUE_WIDTH = ads_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [VALUE_WIDTH-1:0]        value_n,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ads_pkg::SUM_WIDTH-1:0] divisor_sum
);
    import ads_pkg::*;

    localparam int ACC_W = ((VALUE_WIDTH > SUM_WIDTH) ? VALUE_WIDTH : SUM_WIDTH) + 2;
    localparam logic [ACC_W-1:0] SUM_MAX_W = ACC_W'({SUM_WIDTH{1'b1}});

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_CHECK,
        S_DONE
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [VALUE_WIDTH-1:0] n_reg;
    logic [VALUE_WIDTH-1:0] n_next;
    logic [VALUE_WIDTH-1:0] d_reg;
    logic [VALUE_WIDTH-1:0] d_next;
    logic [SUM_WIDTH-1:0]   acc_reg;
    logic [SUM_WIDTH-1:0]   acc_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [SUM_WIDTH-1:0]   divisor_sum_reg;
    logic [SUM_WIDTH-1:0]   divisor_sum_next;

    logic                   div_start;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quo;
    logic [VALUE_WIDTH-1:0] div_rem;

    logic [VALUE_WIDTH-1:0] pair_term;
    logic [ACC_W-1:0]       add_wide;
    logic [ACC_W-1:0]       inc_wide;
    logic [SUM_WIDTH-1:0]   add_sat;
    logic [SUM_WIDTH-1:0]   inc_sat;

    ads_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (n_reg),
        .divisor   (d_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Add d and its cofactor, the cofactor only when it differs from d
    assign pair_term = (div_quo == d_reg) ? '0 : div_quo;
    assign add_wide  = ACC_W'(acc_reg) + ACC_W'(d_reg) + ACC_W'(pair_term);
    assign add_sat   = (add_wide > SUM_MAX_W) ? {SUM_WIDTH{1'b1}} : add_wide[SUM_WIDTH-1:0];

    // Add the divisor 1 at the end
    assign inc_wide  = ACC_W'(acc_reg) + ACC_W'(1);
    assign inc_sat   = (inc_wide > SUM_MAX_W) ? {SUM_WIDTH{1'b1}} : inc_wide[SUM_WIDTH-1:0];

    // Sequence the trial divisions
    always_comb
    begin
        state_next       = state_reg;
        n_next           = n_reg;
        d_next           = d_reg;
        acc_next         = acc_reg;
        out_valid_next   = out_valid_reg && out_stall;
        divisor_sum_next = divisor_sum_reg;
        div_start        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    n_next   = value_n;
                    d_next   = VALUE_WIDTH'(2);
                    acc_next = '0;
                    if (value_n < VALUE_WIDTH'(2))
                        state_next = S_DONE;
                    else
                        state_next = S_START;
                end
            end
            S_START:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (d_reg > div_quo)
                begin
                    acc_next   = inc_sat;
                    state_next = S_DONE;
                end
                else
                begin
                    if (div_rem == '0)
                        acc_next = add_sat;
                    d_next     = d_reg + 1'b1;
                    state_next = S_START;
                end
            end
            S_DONE:
            begin
                // Hold the sum until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    divisor_sum_next = acc_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, working registers and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            n_reg           <= '0;
            d_reg           <= '0;
            acc_reg         <= '0;
            out_valid_reg   <= 1'b0;
            divisor_sum_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            n_reg           <= n_next;
            d_reg           <= d_next;
            acc_reg         <= acc_next;
            out_valid_reg   <= out_valid_next;
            divisor_sum_reg <= divisor_sum_next;
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign divisor_sum = divisor_sum_reg;

endmodule : aliquot_divisor_sum

@@ hdl/ads_checker.sv @@
// Port-level checks for the aliquot divisor sum block, bound to the top level.
// Depends on ads_pkg and aliquot_divisor_sum.
`timescale 1ns / 1ps

module ads_checker #(
    parameter int VALUE_WIDTH = ads_pkg::VALUE_WIDTH_DEFAULT
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic [VALUE_WIDTH-1:0]        value_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [ads_pkg::SUM_WIDTH-1:0] divisor_sum
);
    import ads_pkg::*;

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(divisor_sum))
        else $error("result changed or dropped while stalled");

    // Stall the input once an item is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after an item was taken");

    // Give zero for an input below two once the output is free
    a_small_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid && (value_n < VALUE_WIDTH'(2))
        |=> ##1 (out_valid && (divisor_sum == '0)))
        else $error("input below two did not give a zero sum");

    // Check that the input is still stalled once an item above one enters its search
    a_no_early_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (value_n > VALUE_WIDTH'(1)) |=> ##1 in_stall)
        else $error("input ready too early for an item above one");

endmodule : ads_checker

bind aliquot_divisor_sum ads_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_ads_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .value_n     (value_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .divisor_sum (divisor_sum)
);

@@ tb/aliquot_divisor_sum_test.sv @@
// Self-checking testbench for aliquot_divisor_sum: directed table, then random integers.
// Depends on ads_pkg and the aliquot_divisor_sum RTL; needs no other file.
`timescale 1ns / 1ps

module aliquot_divisor_sum_test;

    import ads_pkg::*;

    localparam int VALUE_WIDTH = VALUE_WIDTH_DEFAULT;
    localparam int RANDOM_ITEMS = 76;
    // Items at the tail of the random part that run without any idling
    localparam int QUIET_ITEMS = 20;
    localparam int DRAIN_CYCLES = 100;

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [SUM_WIDTH-1:0] sum_t;

    // One row of the directed table; known rows carry their sum typed in
    typedef struct packed {
        value_t value;
        logic   known;
        sum_t   sum;
    } dir_row_t;

    localparam int DIR_ROWS = 24;
    localparam dir_row_t DIRECTED [0:DIR_ROWS-1] = '{
        '{value_t'(0),          1'b1, sum_t'(0)},        // zero has no divisors
        '{value_t'(1),          1'b1, sum_t'(0)},        // one has no proper divisors
        '{value_t'(2),          1'b1, sum_t'(1)},
        '{value_t'(3),          1'b1, sum_t'(1)},
        '{value_t'(4),          1'b1, sum_t'(3)},        // square: root counted once
        '{value_t'(6),          1'b1, sum_t'(6)},
        '{value_t'(9),          1'b1, sum_t'(4)},
        '{value_t'(12),         1'b1, sum_t'(16)},
        '{value_t'(25),         1'b1, sum_t'(6)},
        '{value_t'(28),         1'b1, sum_t'(28)},
        '{value_t'(220),        1'b1, sum_t'(284)},
        '{value_t'(284),        1'b1, sum_t'(220)},
        '{value_t'(496),        1'b1, sum_t'(496)},
        '{value_t'(1024),       1'b1, sum_t'(1023)},
        '{value_t'(4097),       1'b0, sum_t'(0)},
        '{value_t'(65521),      1'b1, sum_t'(1)},        // largest 16-bit prime
        '{value_t'(65536),      1'b1, sum_t'(65535)},
        '{value_t'(65537),      1'b1, sum_t'(1)},
        '{value_t'(720720),     1'b0, sum_t'(0)},
        '{value_t'(1000000),    1'b0, sum_t'(0)},
        '{value_t'(1048576),    1'b1, sum_t'(1048575)},
        '{value_t'(32'h00FF_FFFF), 1'b0, sum_t'(0)},
        '{value_t'(32'h5555_5555), 1'b0, sum_t'(0)},
        '{value_t'(32'hFFFF_FFFF), 1'b0, sum_t'(0)}      // all ones: slowest item
    };

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_stall;
    value_t value_n;
    logic   out_valid;
    logic   out_stall;
    sum_t   divisor_sum;

    sum_t pending_sums [$];
    int   mismatch_count;
    bit   quiet;

    aliquot_divisor_sum #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value_n    (value_n),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .divisor_sum(divisor_sum)
    );

    // Generate a 10 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Sum the proper divisors by trial division, saturating at the result width
    function automatic sum_t proper_divisor_sum(value_t n);
        longint unsigned acc;
        longint unsigned num;
        longint unsigned d;
        longint unsigned q;
        longint unsigned sum_max;
        begin
            num = longint'(n);
            sum_max = (64'd1 << SUM_WIDTH) - 1;
            acc = 0;
            if (num < 2)
            begin
                return sum_t'(0);
            end
            for (d = 2; d * d <= num; d++)
            begin
                if (num % d == 0)
                begin
                    q = num / d;
                    acc += (q == d) ? d : d + q;
                end
            end
            acc += 1;
            if (acc > sum_max)
            begin
                acc = sum_max;
            end
            return sum_t'(acc);
        end
    endfunction

    // Pick a random integer, mostly narrow so that items stay short
    function automatic value_t random_value();
        int      bits;
        value_t  mask;
        begin
            if ($urandom_range(0, 99) < 70)
            begin
                bits = $urandom_range(1, 12);
            end
            else
            begin
                bits = $urandom_range(13, 20);
            end
            mask = value_t'((64'd1 << bits) - 1);
            return value_t'($urandom) & mask;
        end
    endfunction

    // Offer one item, hold it until accepted, then record its expected sum
    task automatic send_item(value_t n, sum_t sum);
        begin
            in_valid <= 1'b1;
            value_n  <= n;
            @(posedge clk);
            while (in_stall)
            begin
                @(posedge clk);
            end
            pending_sums = {pending_sums, sum};
        end
    endtask

    // Drop valid for a random burst now and then, except in the quiet tail
    task automatic sender_gap();
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
        end
    endtask

    // Drive reset, walk the directed table, then the random items
    initial
    begin
        value_t n;
        int     row;
        int     item;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        value_n        <= '0;
        mismatch_count = 0;
        quiet          = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < DIR_ROWS; row++)
        begin
            n = DIRECTED[row].value;
            send_item(n, DIRECTED[row].known ? DIRECTED[row].sum : proper_divisor_sum(n));
            sender_gap();
        end

        for (item = 0; item < RANDOM_ITEMS; item++)
        begin
            if (item == RANDOM_ITEMS - QUIET_ITEMS)
            begin
                quiet = 1'b1;
            end
            n = random_value();
            send_item(n, proper_divisor_sum(n));
            sender_gap();
        end
        in_valid <= 1'b0;

        // Drain outstanding sums, then watch for stray results
        while (pending_sums.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Stall the result side in random bursts until the quiet tail
    initial
    begin
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (quiet)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge clk);
                if (!quiet)
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(1, 13)) @(posedge clk);
                end
            end
        end
    end

    // Compare each accepted result with the oldest expected sum
    always @(posedge clk)
    begin
        sum_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_sums.size() == 0)
            begin
                $error("divisor_sum: no result expected, actual %0d", divisor_sum);
                mismatch_count++;
            end
            else
            begin
                want = pending_sums.pop_front();
                if (divisor_sum !== want)
                begin
                    $error("divisor_sum: expected %0d, actual %0d", want, divisor_sum);
                    mismatch_count++;
                end
            end
        end
    end

    // End a hung run after a generous fixed time
    initial
    begin
        #300_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule : aliquot_divisor_sum_test
